// ===== src/muxed_sensor_peak_hold_dump_macros.svh =====
// assertion macros for the peak-hold dump block
// used by the top level only, needs signals clock and reset in scope
`ifndef MUXED_SENSOR_PEAK_HOLD_DUMP_MACROS_SVH
`define MUXED_SENSOR_PEAK_HOLD_DUMP_MACROS_SVH

// same-cycle implication
`define MSPHD_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("msphd same-cycle check failed");

// next-cycle implication
`define MSPHD_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("msphd next-cycle check failed");

`endif

// ===== src/msphd_pkg.sv =====
// shared types and constants for the peak-hold dump block
// no dependencies
package msphd_pkg;

   localparam int SENSOR_COUNT = 25;
   localparam int ROW_COUNT    = 8;
   localparam int LANE_COUNT   = 3;
   localparam int ROW_W        = 3;
   localparam int PEAK_W       = 8;
   localparam int ROW_DATA_W   = PEAK_W * LANE_COUNT;

   localparam logic [4:0] LAST_IDX   = 5'd24;
   localparam logic [5:0] ASCII_ZERO = 6'd48;

   // request function codes
   localparam logic FUNC_SAMPLE = 1'b0;
   localparam logic FUNC_DUMP   = 1'b1;

   // lane codes inside one row: lane 0 holds sensors 1..8, 1 holds 9..16, 2 holds 17..24
   localparam logic [1:0] LANE_LOW  = 2'd0;
   localparam logic [1:0] LANE_MID  = 2'd1;
   localparam logic [1:0] LANE_HIGH = 2'd2;

   typedef logic [PEAK_W-1:0]     peak_type;
   typedef logic [ROW_W-1:0]      row_idx_type;
   typedef logic [ROW_DATA_W-1:0] row_data_type;

   typedef struct packed {
      logic         en;
      row_idx_type  row;
      row_data_type data;
   } wr_type;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_RD   = 4'b0010,
      ST_LOAD = 4'b0100,
      ST_HOLD = 4'b1000
   } state_type;

endpackage

// ===== src/msphd_row_mem.sv =====
// peak store rows: 8 rows of three 8-bit peaks, one write and one registered read
// depends on msphd_pkg
module msphd_row_mem (
   input  logic                  clock,
   input  logic                  reset,
   input  msphd_pkg::wr_type      wr,
   input  msphd_pkg::row_idx_type rd_row,
   output msphd_pkg::row_data_type rd_data
);
   import msphd_pkg::*;

   row_data_type          mem [ROW_COUNT];
   logic [ROW_COUNT-1:0]  vld_ff;
   row_data_type          q_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.row] <= wr.data;
      end
   end

   // rows never written read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (wr.en) begin
         vld_ff[wr.row] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= vld_ff[rd_row] ? mem[rd_row] : '0;
   end

   assign rd_data = q_ff;

endmodule

// ===== src/msphd_digits.sv =====
// binary to three ascii decimal digits for an 8-bit peak
// depends on msphd_pkg
module msphd_digits (
   input  msphd_pkg::peak_type value,
   output logic [5:0]         hundreds_char,
   output logic [5:0]         tens_char,
   output logic [5:0]         ones_char
);
   import msphd_pkg::*;

   logic [1:0]  hund;
   logic [7:0]  hund_sub;
   logic [6:0]  rem;
   logic [14:0] prod;
   logic [3:0]  tens;
   logic [6:0]  tens_x10;
   logic [3:0]  ones;

   always_comb begin
      if (value >= 8'd200) begin
         hund     = 2'd2;
         hund_sub = 8'd200;
      end else if (value >= 8'd100) begin
         hund     = 2'd1;
         hund_sub = 8'd100;
      end else begin
         hund     = 2'd0;
         hund_sub = 8'd0;
      end
   end

   assign rem      = 7'(value - hund_sub);
   // divide by ten via reciprocal, exact below 1029
   assign prod     = 15'(rem) * 15'd205;
   assign tens     = prod[14:11];
   assign tens_x10 = 7'({tens, 3'b000}) + 7'({tens, 1'b0});
   assign ones     = 4'(rem - tens_x10);

   assign hundreds_char = ASCII_ZERO + 6'(hund);
   assign tens_char     = ASCII_ZERO + 6'(tens);
   assign ones_char     = ASCII_ZERO + 6'(ones);

endmodule

// ===== src/muxed_sensor_peak_hold_dump.sv =====
// Peak-hold store for 25 eight-bit sensors. A sample word (func 0) folds four
// samples in: sample_a into sensor 17+m, sample_b into 9+m, sample_c into 1+m
// and sample_d into sensor 25; a sensor takes a sample only when it is strictly
// greater than its peak. Sensors 1..24 live in an 8-row memory, one row per
// mux setting with three peaks each; sensor 25 is a register. Sample words are
// taken one per cycle while no dump runs: the row is read in the accept cycle,
// compared and written back in the next, with the last write forwarded when the
// next word hits the same row. A dump word (func 1) reports all 25 sensors in
// order with their ascii digits, last marked, peaks kept. Each dump entry takes
// a memory read, a load of the output register and a hold while rsp_valid is
// high until rsp_ready; req_ready stays low meanwhile. Reset clears the row
// valid bits at once, so no clearing pass is needed.
// depends on msphd_pkg, msphd_row_mem, msphd_digits and the macros header
module muxed_sensor_peak_hold_dump (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_func,
   input  logic [2:0] req_mux_select,
   input  logic [7:0] req_sample_a,
   input  logic [7:0] req_sample_b,
   input  logic [7:0] req_sample_c,
   input  logic [7:0] req_sample_d,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [4:0] rsp_sensor_number,
   output logic [7:0] rsp_peak_value,
   output logic [5:0] rsp_hundreds_char,
   output logic [5:0] rsp_tens_char,
   output logic [5:0] rsp_ones_char,
   output logic       rsp_last
);
   import msphd_pkg::*;

`include "muxed_sensor_peak_hold_dump_macros.svh"

   state_type    state_ff, state_in;
   logic [4:0]   idx_ff, idx_in;

   // compare / write-back stage for sample words
   logic         s1_vld_ff;
   row_idx_type  s1_row_ff;
   peak_type     s1_low_ff, s1_mid_ff, s1_high_ff;

   // last write, forwarded to a read issued on the same edge
   logic         lst_vld_ff;
   row_idx_type  lst_row_ff;
   row_data_type lst_data_ff;

   peak_type     peak25_ff;

   logic         rsp_valid_ff;
   logic [4:0]   num_ff;
   peak_type     val_ff;
   logic [5:0]   hund_ff, tens_ff, ones_ff;
   logic         last_ff;

   logic         acc_req, acc_sample, acc_dump, acc_rsp;
   row_idx_type  rd_row;
   row_data_type mem_q, base_row, new_row;
   wr_type       wr;
   peak_type     dump_val;
   logic [5:0]   hund_c, tens_c, ones_c;

   assign req_ready  = (state_ff == ST_IDLE);
   assign acc_req    = req_valid && req_ready;
   assign acc_sample = acc_req && (req_func == FUNC_SAMPLE);
   assign acc_dump   = acc_req && (req_func == FUNC_DUMP);
   assign acc_rsp    = rsp_valid_ff && rsp_ready;

   // read address: dump walk owns the port in the read state
   assign rd_row = (state_ff == ST_RD) ? idx_ff[ROW_W-1:0] : req_mux_select;

   msphd_row_mem u_row_mem (
      .clock   (clock),
      .reset   (reset),
      .wr      (wr),
      .rd_row  (rd_row),
      .rd_data (mem_q)
   );

   // fold stage: max per lane against the current row
   always_comb begin
      base_row = (lst_vld_ff && (lst_row_ff == s1_row_ff)) ? lst_data_ff : mem_q;
      new_row[7:0]   = (s1_low_ff  > base_row[7:0])   ? s1_low_ff  : base_row[7:0];
      new_row[15:8]  = (s1_mid_ff  > base_row[15:8])  ? s1_mid_ff  : base_row[15:8];
      new_row[23:16] = (s1_high_ff > base_row[23:16]) ? s1_high_ff : base_row[23:16];
      wr.en   = s1_vld_ff;
      wr.row  = s1_row_ff;
      wr.data = new_row;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         lst_vld_ff <= 1'b0;
         peak25_ff  <= '0;
      end else begin
         s1_vld_ff  <= acc_sample;
         lst_vld_ff <= s1_vld_ff;
         if (acc_sample && (req_sample_d > peak25_ff)) begin
            peak25_ff <= req_sample_d;
         end
      end
   end

   always_ff @(posedge clock) begin
      s1_row_ff   <= req_mux_select;
      s1_low_ff   <= req_sample_c;
      s1_mid_ff   <= req_sample_b;
      s1_high_ff  <= req_sample_a;
      lst_row_ff  <= s1_row_ff;
      lst_data_ff <= new_row;
   end

   // dump entry value: sensor 25 from its register, others by lane of the row
   always_comb begin
      if (idx_ff == LAST_IDX) begin
         dump_val = peak25_ff;
      end else begin
         case (idx_ff[4:3])
            LANE_LOW:  dump_val = mem_q[7:0];
            LANE_MID:  dump_val = mem_q[15:8];
            LANE_HIGH: dump_val = mem_q[23:16];
            default:   dump_val = '0;
         endcase
      end
   end

   msphd_digits u_digits (
      .value         (dump_val),
      .hundreds_char (hund_c),
      .tens_char     (tens_c),
      .ones_char     (ones_c)
   );

   // dump sequencer
   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      case (state_ff)
         ST_IDLE: begin
            idx_in = '0;
            if (acc_dump) begin
               state_in = ST_RD;
            end
         end
         ST_RD: begin
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            state_in = ST_HOLD;
         end
         ST_HOLD: begin
            if (acc_rsp) begin
               if (idx_ff == LAST_IDX) begin
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_RD;
                  idx_in   = idx_ff + 5'd1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         if (state_ff == ST_LOAD) begin
            rsp_valid_ff <= 1'b1;
         end else if (acc_rsp) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // output word register
   always_ff @(posedge clock) begin
      if (state_ff == ST_LOAD) begin
         num_ff  <= idx_ff + 5'd1;
         val_ff  <= dump_val;
         hund_ff <= hund_c;
         tens_ff <= tens_c;
         ones_ff <= ones_c;
         last_ff <= (idx_ff == LAST_IDX);
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_sensor_number = num_ff;
   assign rsp_peak_value    = val_ff;
   assign rsp_hundreds_char = hund_ff;
   assign rsp_tens_char     = tens_ff;
   assign rsp_ones_char     = ones_ff;
   assign rsp_last          = last_ff;

   // a shown word belongs to the hold state of the dump walk
   `MSPHD_ASSERT_NOW(a_rsp_in_hold, rsp_valid_ff, state_ff == ST_HOLD)
   // no sample write-back may still be pending while the dump reads the rows
   `MSPHD_ASSERT_NOW(a_no_fold_in_dump, state_ff == ST_RD, !s1_vld_ff)
   // the last word taken ends the dump
   `MSPHD_ASSERT_NEXT(a_last_ends_dump, acc_rsp && last_ff, req_ready)
   // the marked word is always sensor 25
   `MSPHD_ASSERT_NOW(a_last_is_25, rsp_valid_ff && last_ff, num_ff == 5'd25)

endmodule
